// File: design/tgad_pkg.sv
// Shared types and constants for the TGA image stream decoder.
// Used by every module of the decoder; depends on nothing.
package tgad_pkg;

   localparam logic [7:0] RLE_IMAGE_KIND = 8'd10;
   localparam logic [7:0] DEPTH_16       = 8'd16;
   localparam logic [7:0] DEPTH_24       = 8'd24;
   localparam logic [7:0] DEPTH_32       = 8'd32;

   // Header byte positions (the header is 18 bytes long).
   localparam logic [7:0] HDR_ID_LENGTH  = 8'd0;
   localparam logic [7:0] HDR_IMAGE_KIND = 8'd2;
   localparam logic [7:0] HDR_WIDTH_LO   = 8'd12;
   localparam logic [7:0] HDR_WIDTH_HI   = 8'd13;
   localparam logic [7:0] HDR_HEIGHT_LO  = 8'd14;
   localparam logic [7:0] HDR_HEIGHT_HI  = 8'd15;
   localparam logic [7:0] HDR_DEPTH      = 8'd16;
   localparam logic [7:0] HDR_LAST       = 8'd17;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        has_alpha;
      logic [7:0]  repeat_count;
      logic        last_in_image;
      logic        format_error;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } rsp_word_type;

endpackage

// File: design/tgad_stream_if.sv
// Valid/ready stream channel carrying one word per handshake.
// The word type is a parameter; used with the types of tgad_pkg.
interface tgad_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/tga_image_stream_decoder_top.sv
// TGA image stream decoder, top level.
// Uses tgad_pkg, tgad_stream_if, tgad_in_reg, tgad_parser and tgad_out_reg.
//
// req_stream carries the file one byte per word; start_of_file marks byte 0
// of a new file and restarts header parsing at any point. rsp_stream carries
// one decoded RGBA pixel (with a repeat count for RLE runs) or a single
// format-error word for an unsupported bit depth. Header bytes, ID bytes,
// packet headers and partial pixel bytes give no response word.
// A byte is registered at the input and decoded from the input register, and
// its response word is loaded into the output register when the byte advances.
// The response passes through both registers, first the input register and
// then the output register, before it can be taken. One byte is taken every
// cycle while the receiver does not stall; the parser updates its state once per byte.
// Reset clears both registers and puts the parser in the header phase, so
// the first bytes are read as a header even without start_of_file.
// When the receiver stalls with a word waiting in the output register, the
// byte in the input register waits as well, whether or not it gives a
// response. req_stream.ready drops once both registers are full, and it
// follows rsp_stream.ready within the same cycle.
module tga_image_stream_decoder_top (
   input  logic          clock,
   input  logic          reset,
   tgad_stream_if.sink   req_stream,
   tgad_stream_if.source rsp_stream
);

   logic                   word_valid;
   tgad_pkg::req_word_type word;
   logic                   result_valid;
   tgad_pkg::rsp_word_type result;
   logic                   out_free;
   logic                   advance;

   assign advance = word_valid && out_free;

   tgad_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   tgad_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .word         (word),
      .result_valid (result_valid),
      .result       (result)
   );

   tgad_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .rsp_stream (rsp_stream),
      .load       (advance && result_valid),
      .result     (result),
      .free       (out_free)
   );

endmodule

// File: design/tgad_in_reg.sv
// Input register stage: captures one byte word from the request channel.
// Depends on tgad_pkg and tgad_stream_if.
module tgad_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   tgad_stream_if.sink           req_stream,
   input  logic                  advance,
   output logic                  word_valid,
   output tgad_pkg::req_word_type word
);

   logic                  valid_ff, valid_in;
   tgad_pkg::req_word_type word_ff, word_in;

   assign req_stream.ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req_stream.ready) begin
         valid_in = req_stream.valid;
         word_in  = req_stream.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

// File: design/tgad_parser.sv
// Header parser and pixel decoder: holds the parse state and computes the
// result for the registered input byte. Depends on tgad_pkg.
module tgad_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  tgad_pkg::req_word_type word,
   output logic                   result_valid,
   output tgad_pkg::rsp_word_type result
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_IDSKIP,
      PH_PLAIN,
      PH_PKTHDR,
      PH_PKTPIX,
      PH_DONE
   } phase_type;

   phase_type    phase_ff, phase_in, cur_phase;
   logic [7:0]   index_ff, index_in, cur_index;
   logic [7:0]   id_len_ff, id_len_in, cur_id_len;
   logic [7:0]   kind_ff, kind_in, cur_kind;
   logic [15:0]  width_ff, width_in, cur_width;
   logic [15:0]  height_ff, height_in, cur_height;
   logic [7:0]   depth_ff, depth_in, cur_depth;
   logic [31:0]  pix_left_ff, pix_left_in, cur_pix_left;
   logic [7:0]   pkt_left_ff, pkt_left_in, cur_pkt_left;
   logic         pkt_run_ff, pkt_run_in, cur_pkt_run;
   logic [1:0]   bip_ff, bip_in, cur_bip;
   logic [23:0]  gather_ff, gather_in, cur_gather;

   logic [31:0]  pix_total;
   logic [7:0]   byte_val;
   logic         sof;
   logic         pixel_done;
   logic [15:0]  word16;
   logic [7:0]   red, green, blue, alpha;
   logic         has_alpha;
   logic         depth_ok;
   logic [7:0]   count;
   logic [7:0]   rep;
   logic [7:0]   index_next;
   logic         is_rle;

   assign byte_val = word.data_byte;
   assign sof      = word.start_of_file;

   // A start-of-file byte sees the reset state.
   always_comb begin
      cur_phase    = sof ? PH_HEADER : phase_ff;
      cur_index    = sof ? '0 : index_ff;
      cur_id_len   = sof ? '0 : id_len_ff;
      cur_kind     = sof ? '0 : kind_ff;
      cur_width    = sof ? '0 : width_ff;
      cur_height   = sof ? '0 : height_ff;
      cur_depth    = sof ? '0 : depth_ff;
      cur_pix_left = sof ? '0 : pix_left_ff;
      cur_pkt_left = sof ? '0 : pkt_left_ff;
      cur_pkt_run  = sof ? 1'b0 : pkt_run_ff;
      cur_bip      = sof ? '0 : bip_ff;
      cur_gather   = sof ? '0 : gather_ff;
   end

   assign pix_total  = cur_width * cur_height;
   assign is_rle     = (cur_kind == tgad_pkg::RLE_IMAGE_KIND);
   assign depth_ok   = (cur_depth == tgad_pkg::DEPTH_24) || (cur_depth == tgad_pkg::DEPTH_32) ||
                       ((cur_depth == tgad_pkg::DEPTH_16) && !is_rle);
   assign pixel_done = ({3'b000, cur_bip} + 5'd1) >= cur_depth[7:3];
   assign word16     = {byte_val, cur_gather[7:0]};
   assign index_next = cur_index + 8'd1;

   // Color conversion of the completed pixel.
   always_comb begin
      if (cur_depth == tgad_pkg::DEPTH_16) begin
         blue      = {word16[4:0], 3'b000};
         green     = {word16[9:5], 3'b000};
         red       = {word16[14:10], 3'b000};
         alpha     = 8'd0;
         has_alpha = 1'b0;
      end else if (cur_depth == tgad_pkg::DEPTH_24) begin
         blue      = cur_gather[7:0];
         green     = cur_gather[15:8];
         red       = byte_val;
         alpha     = 8'd0;
         has_alpha = 1'b0;
      end else begin
         blue      = cur_gather[7:0];
         green     = cur_gather[15:8];
         red       = cur_gather[23:16];
         alpha     = byte_val;
         has_alpha = 1'b1;
      end
   end

   // Packet header: low seven bits plus one, clipped to the pixels left.
   always_comb begin
      count = {1'b0, byte_val[6:0]} + 8'd1;
      if ({24'd0, count} > cur_pix_left) begin
         count = cur_pix_left[7:0];
      end
   end

   assign rep = cur_pkt_run ? cur_pkt_left : 8'd1;

   always_comb begin
      phase_in     = cur_phase;
      index_in     = cur_index;
      id_len_in    = cur_id_len;
      kind_in      = cur_kind;
      width_in     = cur_width;
      height_in    = cur_height;
      depth_in     = cur_depth;
      pix_left_in  = cur_pix_left;
      pkt_left_in  = cur_pkt_left;
      pkt_run_in   = cur_pkt_run;
      bip_in       = cur_bip;
      gather_in    = cur_gather;
      result_valid = 1'b0;
      result       = '0;

      case (cur_phase)
         PH_HEADER: begin
            case (cur_index)
               tgad_pkg::HDR_ID_LENGTH:  id_len_in = byte_val;
               tgad_pkg::HDR_IMAGE_KIND: kind_in = byte_val;
               tgad_pkg::HDR_WIDTH_LO:   width_in = {cur_width[15:8], byte_val};
               tgad_pkg::HDR_WIDTH_HI:   width_in = {byte_val, cur_width[7:0]};
               tgad_pkg::HDR_HEIGHT_LO:  height_in = {cur_height[15:8], byte_val};
               tgad_pkg::HDR_HEIGHT_HI:  height_in = {byte_val, cur_height[7:0]};
               tgad_pkg::HDR_DEPTH:      depth_in = byte_val;
               default: ;
            endcase
            if (cur_index < tgad_pkg::HDR_LAST) begin
               index_in = index_next;
            end else begin
               index_in    = '0;
               pix_left_in = pix_total;
               if (!depth_ok) begin
                  phase_in            = PH_DONE;
                  result_valid        = 1'b1;
                  result.format_error = 1'b1;
               end else if (cur_id_len != 8'd0) begin
                  phase_in = PH_IDSKIP;
               end else begin
                  bip_in    = '0;
                  gather_in = '0;
                  if (pix_total == 32'd0) begin
                     phase_in = PH_DONE;
                  end else if (is_rle) begin
                     phase_in = PH_PKTHDR;
                  end else begin
                     phase_in = PH_PLAIN;
                  end
               end
            end
         end
         PH_IDSKIP: begin
            index_in = index_next;
            if (index_next >= cur_id_len) begin
               index_in  = '0;
               bip_in    = '0;
               gather_in = '0;
               if (cur_pix_left == 32'd0) begin
                  phase_in = PH_DONE;
               end else if (is_rle) begin
                  phase_in = PH_PKTHDR;
               end else begin
                  phase_in = PH_PLAIN;
               end
            end
         end
         PH_PLAIN, PH_PKTPIX: begin
            if (!pixel_done) begin
               bip_in = cur_bip + 2'd1;
               case (cur_bip)
                  2'd0:    gather_in[7:0] = byte_val;
                  2'd1:    gather_in[15:8] = byte_val;
                  default: gather_in[23:16] = byte_val;
               endcase
            end else begin
               bip_in    = '0;
               gather_in = '0;
               if (cur_phase == PH_PLAIN) begin
                  pix_left_in         = cur_pix_left - 32'd1;
                  result.repeat_count = 8'd1;
                  if (pix_left_in == 32'd0) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  pkt_left_in         = cur_pkt_run ? 8'd0 : cur_pkt_left - 8'd1;
                  pix_left_in         = ({24'd0, rep} > cur_pix_left) ? 32'd0 :
                                        cur_pix_left - {24'd0, rep};
                  result.repeat_count = rep;
                  if (pix_left_in == 32'd0) begin
                     phase_in = PH_DONE;
                  end else if (pkt_left_in == 8'd0) begin
                     phase_in = PH_PKTHDR;
                  end
               end
               result_valid         = 1'b1;
               result.red           = red;
               result.green         = green;
               result.blue          = blue;
               result.alpha         = alpha;
               result.has_alpha     = has_alpha;
               result.last_in_image = (pix_left_in == 32'd0);
            end
         end
         PH_PKTHDR: begin
            pkt_run_in  = byte_val[7];
            pkt_left_in = count;
            bip_in      = '0;
            gather_in   = '0;
            phase_in    = PH_PKTPIX;
         end
         default: ;
      endcase

      result.image_width  = width_in;
      result.image_height = height_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         index_ff    <= '0;
         id_len_ff   <= '0;
         kind_ff     <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         depth_ff    <= '0;
         pix_left_ff <= '0;
         pkt_left_ff <= '0;
         pkt_run_ff  <= 1'b0;
         bip_ff      <= '0;
         gather_ff   <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         index_ff    <= index_in;
         id_len_ff   <= id_len_in;
         kind_ff     <= kind_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         depth_ff    <= depth_in;
         pix_left_ff <= pix_left_in;
         pkt_left_ff <= pkt_left_in;
         pkt_run_ff  <= pkt_run_in;
         bip_ff      <= bip_in;
         gather_ff   <= gather_in;
      end
   end

endmodule

// File: design/tgad_out_reg.sv
// Output register: holds one result word until the response channel takes it.
// Depends on tgad_pkg and tgad_stream_if.
module tgad_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   tgad_stream_if.source          rsp_stream,
   input  logic                   load,
   input  tgad_pkg::rsp_word_type result,
   output logic                   free
);

   logic                   valid_ff, valid_in;
   tgad_pkg::rsp_word_type word_ff, word_in;

   // The register can take a new word when empty or being emptied this cycle.
   assign free = !valid_ff || rsp_stream.ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (free) begin
         valid_in = load;
         word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_stream.valid   = valid_ff;
   assign rsp_stream.payload = word_ff;

endmodule

// File: sim/tga_image_stream_decoder_checker.sv
// Checker for the TGA image stream decoder: watches both channels, predicts
// each response word from the accepted bytes and compares it field by field.
// Depends on tgad_pkg for the word types and the header constants.
module tga_image_stream_decoder_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  tgad_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tgad_pkg::rsp_word_type rsp_word,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PARSE_HEADER,
      PARSE_ID_SKIP,
      PARSE_RAW,
      PARSE_PACKET_HEAD,
      PARSE_PACKET_PIXEL,
      PARSE_DONE
   } parse_phase_type;

   parse_phase_type phase;
   logic [8:0]      hdr_index;
   logic [7:0]      id_length;
   logic [7:0]      image_kind;
   logic [15:0]     width_store;
   logic [15:0]     height_store;
   logic [7:0]      depth_bits;
   logic [31:0]     pixels_left;
   logic [7:0]      packet_left;
   logic            packet_is_run;
   logic [1:0]      byte_pos;
   logic [23:0]     pixel_gather;

   tgad_pkg::rsp_word_type expected_pixels[$];
   tgad_pkg::rsp_word_type predicted;
   tgad_pkg::rsp_word_type oldest;
   int                     mismatch_total = 0;

   function automatic void clear_decoder();
      phase         = PARSE_HEADER;
      hdr_index     = '0;
      id_length     = '0;
      image_kind    = '0;
      width_store   = '0;
      height_store  = '0;
      depth_bits    = '0;
      pixels_left   = '0;
      packet_left   = '0;
      packet_is_run = 1'b0;
      byte_pos      = '0;
      pixel_gather  = '0;
   endfunction

   function automatic void enter_pixels();
      byte_pos     = '0;
      pixel_gather = '0;
      if (pixels_left == 0)
         phase = PARSE_DONE;
      else if (image_kind == tgad_pkg::RLE_IMAGE_KIND)
         phase = PARSE_PACKET_HEAD;
      else
         phase = PARSE_RAW;
   endfunction

   function automatic tgad_pkg::rsp_word_type pixel_word(
      input logic [7:0] r, g, bl, a,
      input logic ha, input logic [7:0] rep,
      input logic last, err);
      tgad_pkg::rsp_word_type w;
      w.red           = r;
      w.green         = g;
      w.blue          = bl;
      w.alpha         = a;
      w.has_alpha     = ha;
      w.repeat_count  = rep;
      w.last_in_image = last;
      w.format_error  = err;
      w.image_width   = width_store;
      w.image_height  = height_store;
      return w;
   endfunction

   // Collects one pixel byte; returns 1 once the pixel is complete.
   function automatic logic gather_pixel(input logic [7:0] b, output logic [7:0] r, g, bl, a,
                                         output logic ha);
      int          bytes_per_pixel;
      logic [15:0] word16;
      bytes_per_pixel = int'(depth_bits) >> 3;
      r  = '0;
      g  = '0;
      bl = '0;
      a  = '0;
      ha = 1'b0;
      if (int'(byte_pos) + 1 < bytes_per_pixel) begin
         pixel_gather = pixel_gather | (24'(b) << (8 * int'(byte_pos)));
         byte_pos     = byte_pos + 2'd1;
         return 1'b0;
      end
      if (depth_bits == tgad_pkg::DEPTH_16) begin
         word16 = {b, pixel_gather[7:0]};
         bl = {word16[4:0], 3'b000};
         g  = {word16[9:5], 3'b000};
         r  = {word16[14:10], 3'b000};
      end else if (depth_bits == tgad_pkg::DEPTH_24) begin
         bl = pixel_gather[7:0];
         g  = pixel_gather[15:8];
         r  = b;
      end else begin
         bl = pixel_gather[7:0];
         g  = pixel_gather[15:8];
         r  = pixel_gather[23:16];
         a  = b;
         ha = 1'b1;
      end
      byte_pos     = '0;
      pixel_gather = '0;
      return 1'b1;
   endfunction

   // Advances the decoder by one byte; returns 1 when the byte yields a word.
   function automatic logic decode_byte(input tgad_pkg::req_word_type w,
                                        output tgad_pkg::rsp_word_type px);
      logic [7:0]  b;
      logic [7:0]  r, g, bl, a;
      logic        ha;
      logic [31:0] count;
      logic [7:0]  rep;
      logic        depth_ok;
      b  = w.data_byte;
      px = '0;
      if (w.start_of_file)
         clear_decoder();
      case (phase)
         PARSE_HEADER: begin
            if (hdr_index == 9'(tgad_pkg::HDR_ID_LENGTH))
               id_length = b;
            else if (hdr_index == 9'(tgad_pkg::HDR_IMAGE_KIND))
               image_kind = b;
            else if (hdr_index == 9'(tgad_pkg::HDR_WIDTH_LO))
               width_store[7:0] = b;
            else if (hdr_index == 9'(tgad_pkg::HDR_WIDTH_HI))
               width_store[15:8] = b;
            else if (hdr_index == 9'(tgad_pkg::HDR_HEIGHT_LO))
               height_store[7:0] = b;
            else if (hdr_index == 9'(tgad_pkg::HDR_HEIGHT_HI))
               height_store[15:8] = b;
            else if (hdr_index == 9'(tgad_pkg::HDR_DEPTH))
               depth_bits = b;
            if (hdr_index < 9'(tgad_pkg::HDR_LAST)) begin
               hdr_index = hdr_index + 9'd1;
               return 1'b0;
            end
            hdr_index   = '0;
            pixels_left = 32'(width_store) * 32'(height_store);
            depth_ok = (depth_bits == tgad_pkg::DEPTH_24) ||
                       (depth_bits == tgad_pkg::DEPTH_32) ||
                       (depth_bits == tgad_pkg::DEPTH_16 &&
                        image_kind != tgad_pkg::RLE_IMAGE_KIND);
            if (!depth_ok) begin
               phase = PARSE_DONE;
               px = pixel_word('0, '0, '0, '0, 1'b0, '0, 1'b0, 1'b1);
               return 1'b1;
            end
            if (id_length != 0)
               phase = PARSE_ID_SKIP;
            else
               enter_pixels();
            return 1'b0;
         end
         PARSE_ID_SKIP: begin
            hdr_index = hdr_index + 9'd1;
            if (hdr_index >= 9'(id_length)) begin
               hdr_index = '0;
               enter_pixels();
            end
            return 1'b0;
         end
         PARSE_RAW: begin
            if (!gather_pixel(b, r, g, bl, a, ha))
               return 1'b0;
            pixels_left = pixels_left - 32'd1;
            if (pixels_left == 0)
               phase = PARSE_DONE;
            px = pixel_word(r, g, bl, a, ha, 8'd1, pixels_left == 0, 1'b0);
            return 1'b1;
         end
         PARSE_PACKET_HEAD: begin
            // The low seven bits hold the count minus one for both packet kinds.
            packet_is_run = b[7];
            count = 32'(b[6:0]) + 32'd1;
            if (count > pixels_left)
               count = pixels_left;
            packet_left  = count[7:0];
            byte_pos     = '0;
            pixel_gather = '0;
            phase        = PARSE_PACKET_PIXEL;
            return 1'b0;
         end
         PARSE_PACKET_PIXEL: begin
            if (!gather_pixel(b, r, g, bl, a, ha))
               return 1'b0;
            if (packet_is_run) begin
               rep         = packet_left;
               packet_left = '0;
            end else begin
               rep         = 8'd1;
               packet_left = packet_left - 8'd1;
            end
            pixels_left = (32'(rep) > pixels_left) ? 32'd0 : pixels_left - 32'(rep);
            if (pixels_left == 0)
               phase = PARSE_DONE;
            else if (packet_left == 0)
               phase = PARSE_PACKET_HEAD;
            px = pixel_word(r, g, bl, a, ha, rep, pixels_left == 0, 1'b0);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_total++;
      end
   endtask

   // Responses are checked before the byte of the same edge is predicted; a
   // word can never belong to a byte accepted at that very edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %0h", $time, rsp_word);
               mismatch_total++;
            end else begin
               oldest = expected_pixels.pop_front();
               compare_field("red", 16'(oldest.red), 16'(rsp_word.red));
               compare_field("green", 16'(oldest.green), 16'(rsp_word.green));
               compare_field("blue", 16'(oldest.blue), 16'(rsp_word.blue));
               compare_field("alpha", 16'(oldest.alpha), 16'(rsp_word.alpha));
               compare_field("has_alpha", 16'(oldest.has_alpha), 16'(rsp_word.has_alpha));
               compare_field("repeat_count", 16'(oldest.repeat_count),
                             16'(rsp_word.repeat_count));
               compare_field("last_in_image", 16'(oldest.last_in_image),
                             16'(rsp_word.last_in_image));
               compare_field("format_error", 16'(oldest.format_error),
                             16'(rsp_word.format_error));
               compare_field("image_width", oldest.image_width, rsp_word.image_width);
               compare_field("image_height", oldest.image_height, rsp_word.image_height);
            end
         end
         if (req_valid && req_ready) begin
            if (decode_byte(req_word, predicted))
               expected_pixels.push_back(predicted);
         end
      end
      fail_count    <= mismatch_total;
      pending_count <= expected_pixels.size();
   end

endmodule

// File: sim/tga_image_stream_decoder_top_tb.sv
// Testbench top for the TGA image stream decoder: builds TGA byte streams,
// drives them with random idling and gives the verdict.
// Depends on tgad_pkg, tgad_stream_if, tga_image_stream_decoder_top and tga_image_stream_decoder_checker.
module tga_image_stream_decoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CLOCK_HALF       = 2;
   localparam int         RESET_CYCLES     = 7;
   localparam int         RANDOM_BYTES     = 1150;
   localparam int         WATCHDOG_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES     = 8;
   localparam logic [7:0] PLAIN_IMAGE_KIND = 8'd2;
   localparam logic [7:0] DEPTH_8          = 8'd8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int counted_bytes = 0;
   int quiet_cycles  = 0;
   int fail_count;
   int pending_count;

   logic [7:0] file_q[$];

   tgad_stream_if #(.payload_type(tgad_pkg::req_word_type)) req_if ();
   tgad_stream_if #(.payload_type(tgad_pkg::rsp_word_type)) rsp_if ();

   tga_image_stream_decoder_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   tga_image_stream_decoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_word      (req_if.payload),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_word      (rsp_if.payload),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic sof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= '{data_byte: b, start_of_file: sof};
      do
         @(posedge clock);
      while (!req_if.ready);
   endtask

   task automatic send_file(input logic first_sof);
      foreach (file_q[i]) begin
         send_byte(file_q[i], first_sof && (i == 0));
         counted_bytes++;
      end
      file_q.delete();
   endtask

   task automatic push_header(input logic [7:0] id_len, kind, input logic [15:0] w, h,
                              input logic [7:0] depth);
      file_q.push_back(id_len);
      file_q.push_back(8'($urandom));
      file_q.push_back(kind);
      // Color map specification and image origin, which the decoder skips.
      repeat (9) file_q.push_back(8'($urandom));
      file_q.push_back(w[7:0]);
      file_q.push_back(w[15:8]);
      file_q.push_back(h[7:0]);
      file_q.push_back(h[15:8]);
      file_q.push_back(depth);
      file_q.push_back(8'($urandom));
      repeat (int'(id_len)) file_q.push_back(8'($urandom));
   endtask

   task automatic push_fill(input int n, input logic [7:0] value);
      repeat (n) file_q.push_back(value);
   endtask

   task automatic push_random(input int n);
      repeat (n) file_q.push_back(8'($urandom));
   endtask

   task automatic random_file();
      logic [7:0]  id_len, kind, depth;
      logic [15:0] w, h;
      logic        huge, run, depth_ok;
      int          bpp, left, count, taken, shape;
      id_len = 8'd0;
      if ($urandom_range(9) >= 7)
         id_len = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
      shape = $urandom_range(9);
      kind = (shape < 5) ? tgad_pkg::RLE_IMAGE_KIND :
             (shape < 9) ? PLAIN_IMAGE_KIND : 8'($urandom);
      case ($urandom_range(2))
         0: depth = tgad_pkg::DEPTH_16;
         1: depth = tgad_pkg::DEPTH_24;
         default: depth = tgad_pkg::DEPTH_32;
      endcase
      if (kind == tgad_pkg::RLE_IMAGE_KIND && depth == tgad_pkg::DEPTH_16 &&
          $urandom_range(3) != 0)
         depth = tgad_pkg::DEPTH_24;
      if ($urandom_range(19) == 0)
         depth = 8'($urandom);
      shape = $urandom_range(99);
      huge  = 1'b0;
      w = 16'($urandom_range(1, 6));
      h = 16'($urandom_range(1, 4));
      if (shape < 4) begin
         if ($urandom_range(1)) w = '0; else h = '0;
         if ($urandom_range(1)) w = w | 16'($urandom); else h = h | 16'($urandom);
         if (w != 0 && h != 0) w = '0;
      end else if (shape < 10) begin
         // Large images are never finished; the next file restarts the decoder.
         w = 16'($urandom);
         h = 16'($urandom);
         huge = 1'b1;
      end
      push_header(id_len, kind, w, h, depth);
      depth_ok = (depth == tgad_pkg::DEPTH_24) || (depth == tgad_pkg::DEPTH_32) ||
                 (depth == tgad_pkg::DEPTH_16 && kind != tgad_pkg::RLE_IMAGE_KIND);
      bpp  = int'(depth) >> 3;
      left = huge ? $urandom_range(3, 10) : int'(w) * int'(h);
      if (!depth_ok) begin
         push_random($urandom_range(0, 6));
      end else if (kind == tgad_pkg::RLE_IMAGE_KIND) begin
         while (left > 0) begin
            run = $urandom_range(1);
            if ($urandom_range(9) == 0)
               count = $urandom_range(1, 128);
            else
               count = $urandom_range(1, (left + 2 > 128) ? 128 : left + 2);
            file_q.push_back(run ? 8'(127 + count) : 8'(count - 1));
            taken = (count < left) ? count : left;
            push_random((run ? 1 : taken) * bpp);
            left -= taken;
         end
      end else begin
         push_random(left * bpp);
      end
      if ($urandom_range(4) == 0)
         push_random($urandom_range(1, 4));
      if ($urandom_range(99) < 8 && file_q.size() > 1) begin
         left = $urandom_range(1, file_q.size() - 1);
         while (file_q.size() > left) void'(file_q.pop_back());
      end
      send_file(1'b1);
   endtask

   initial begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Right after reset the header is parsed without a start-of-file mark.
      push_header(8'd0, PLAIN_IMAGE_KIND, 16'd2, 16'd1, tgad_pkg::DEPTH_24);
      push_fill(3, 8'h00);
      push_fill(3, 8'hff);
      send_file(1'b0);
      // Four channels behind an ID field.
      push_header(8'd3, PLAIN_IMAGE_KIND, 16'd1, 16'd2, tgad_pkg::DEPTH_32);
      push_fill(4, 8'hff);
      push_fill(4, 8'h00);
      send_file(1'b1);
      // Sixteen-bit pixels ignore the top bit; bytes after the image are dropped.
      push_header(8'd0, PLAIN_IMAGE_KIND, 16'd2, 16'd1, tgad_pkg::DEPTH_16);
      push_fill(2, 8'hff);
      file_q.push_back(8'h00);
      file_q.push_back(8'h80);
      file_q.push_back(8'h55);
      file_q.push_back(8'haa);
      send_file(1'b1);
      // A run of two, then a raw packet of five clipped to the one pixel left.
      push_header(8'd0, tgad_pkg::RLE_IMAGE_KIND, 16'd3, 16'd1, tgad_pkg::DEPTH_24);
      file_q.push_back(8'h81);
      push_random(3);
      file_q.push_back(8'h04);
      push_random(6);
      send_file(1'b1);
      // The longest run is clipped to the four pixels of the image.
      push_header(8'd0, tgad_pkg::RLE_IMAGE_KIND, 16'd2, 16'd2, tgad_pkg::DEPTH_32);
      file_q.push_back(8'hff);
      push_random(4);
      send_file(1'b1);
      // Rejected depths: sixteen bits with run-length coding, and eight bits.
      push_header(8'd0, tgad_pkg::RLE_IMAGE_KIND, 16'd1, 16'd1, tgad_pkg::DEPTH_16);
      push_random(2);
      send_file(1'b1);
      push_header(8'd0, PLAIN_IMAGE_KIND, 16'd1, 16'd1, DEPTH_8);
      push_random(2);
      send_file(1'b1);
      // An empty image yields nothing for the bytes after its header.
      push_header(8'd0, PLAIN_IMAGE_KIND, 16'd0, 16'd5, tgad_pkg::DEPTH_24);
      push_random(3);
      send_file(1'b1);
      // Largest dimensions, cut inside a pixel by the restart that follows.
      push_header(8'd0, PLAIN_IMAGE_KIND, 16'hffff, 16'hffff, tgad_pkg::DEPTH_32);
      push_random(6);
      send_file(1'b1);
      // A restart in the middle of a header.
      push_header(8'd0, PLAIN_IMAGE_KIND, 16'd1, 16'd1, tgad_pkg::DEPTH_24);
      while (file_q.size() > 9) void'(file_q.pop_back());
      send_file(1'b1);

      counted_bytes = 0;
      while (counted_bytes < RANDOM_BYTES) begin
         case (counted_bytes * 4 / RANDOM_BYTES)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         random_file();
      end
      req_if.valid <= 1'b0;
      stall_pct = 0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: tga_image_stream_decoder_top.f
design/tgad_pkg.sv
design/tgad_stream_if.sv
design/tgad_in_reg.sv
design/tgad_parser.sv
design/tgad_out_reg.sv
design/tga_image_stream_decoder_top.sv
sim/tga_image_stream_decoder_checker.sv
sim/tga_image_stream_decoder_top_tb.sv
